// ===== hw/rtl/slr_pkg.sv =====
// Shared types, widths and codes for the sliding-log rate limiter.
package slr_pkg;

  // Fixed field widths
  localparam int CLIENT_W   = 6;
  localparam int STAMP_W    = 48;
  localparam int MAXREQ_W   = 5;
  localparam int WINDOW_W   = 32;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  // Default sizing
  localparam int NUM_CLIENTS_DEF = 64;
  localparam int LOG_DEPTH_DEF   = 16;

  // Depth of the request queue and of the result queue
  localparam int QUEUE_DEPTH = 2;

  // Register reset values
  localparam logic [MAXREQ_W-1:0] REQ_LIMIT_RST = MAXREQ_W'(8);
  localparam logic [WINDOW_W-1:0] WINDOW_MS_RST = WINDOW_W'(1000);

  // Register indexes (paddr[2])
  localparam logic REG_REQ_LIMIT = 1'b0;
  localparam logic REG_WINDOW_MS = 1'b1;

  // Classified request handed from front to back
  typedef struct packed {
    logic                in_range;
    logic [CLIENT_W-1:0] client_index;
    logic [STAMP_W-1:0]  timestamp_ms;
  } req_t;

  // Configuration seen by the back end
  typedef struct packed {
    logic [MAXREQ_W-1:0] req_limit;
    logic [WINDOW_W-1:0] window_ms;
  } cfg_t;

  // Back-end sequencer states
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_META,
    ST_STAMP,
    ST_DECIDE
  } back_state_t;

endpackage

// ===== hw/rtl/sliding_log_rate_limiter.sv =====
// Flow: a request leaves the request queue in ST_IDLE, reads its head and count in ST_META,
// walks its expiring stamps in ST_STAMP (0 to LOG_DEPTH reads) and is decided in ST_DECIDE;
// an out-of-range request is answered from ST_IDLE. No new request is taken until the last
// is through; each stored stamp is read at most once as it expires, plus at most one read
// that stops the walk. Reset (rst_n low, synchronous): queues emptied, registers to defaults,
// then a clearing pass zeroes every ring head and count; full stays high meanwhile.
module sliding_log_rate_limiter #(
  parameter int NUM_CLIENTS = slr_pkg::NUM_CLIENTS_DEF,
  parameter int LOG_DEPTH   = slr_pkg::LOG_DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // Request channel
  input  logic                           push,
  output logic                           full,
  input  logic [slr_pkg::CLIENT_W-1:0]   in_client_index,
  input  logic [slr_pkg::STAMP_W-1:0]    in_timestamp_ms,
  // Result channel
  output logic                           empty,
  input  logic                           pop,
  output logic                           out_allowed,
  // Configuration port
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [slr_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [slr_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [slr_pkg::CFG_DATA_W-1:0] prdata,
  output logic                           pready
);

  slr_pkg::cfg_t cfg_r, cfg_nxt;
  slr_pkg::req_t req_data;
  logic          req_empty, req_pop, busy, cfg_wr;

  // Register write on the access cycle
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr) begin
      case (paddr[2])
        slr_pkg::REG_REQ_LIMIT: cfg_nxt.req_limit = pwdata[slr_pkg::MAXREQ_W-1:0];
        slr_pkg::REG_WINDOW_MS: cfg_nxt.window_ms = pwdata[slr_pkg::WINDOW_W-1:0];
        default:                cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.req_limit <= slr_pkg::REQ_LIMIT_RST;
      cfg_r.window_ms <= slr_pkg::WINDOW_MS_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Register read-back
  always_comb begin
    case (paddr[2])
      slr_pkg::REG_REQ_LIMIT: prdata = slr_pkg::CFG_DATA_W'(cfg_r.req_limit);
      slr_pkg::REG_WINDOW_MS: prdata = slr_pkg::CFG_DATA_W'(cfg_r.window_ms);
      default:                prdata = '0;
    endcase
  end

  slr_front #(
    .NUM_CLIENTS (NUM_CLIENTS)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .push         (push),
    .client_index (in_client_index),
    .timestamp_ms (in_timestamp_ms),
    .busy         (busy),
    .full         (full),
    .req_pop      (req_pop),
    .req_data     (req_data),
    .req_empty    (req_empty)
  );

  slr_back #(
    .NUM_CLIENTS (NUM_CLIENTS),
    .LOG_DEPTH   (LOG_DEPTH)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg_r),
    .req_data    (req_data),
    .req_empty   (req_empty),
    .req_pop     (req_pop),
    .busy        (busy),
    .out_allowed (out_allowed),
    .empty       (empty),
    .pop         (pop)
  );

endmodule

// ===== hw/rtl/slr_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module slr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== hw/rtl/slr_fifo.sv =====
// Small first-in first-out queue with full and empty flags.
module slr_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2,
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CW = $clog2(DEPTH + 1)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             empty
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic             do_push, do_pop;

  assign full     = (count_r == CW'(DEPTH));
  assign empty    = (count_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = mem_r[rd_ptr_r];

  // Pointer and fill bookkeeping
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Payload storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ===== hw/rtl/slr_front.sv =====
// Front end: accepts requests, flags out-of-range clients, queues them.
module slr_front #(
  parameter int NUM_CLIENTS = slr_pkg::NUM_CLIENTS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         push,
  input  logic [slr_pkg::CLIENT_W-1:0] client_index,
  input  logic [slr_pkg::STAMP_W-1:0]  timestamp_ms,
  input  logic                         busy,
  output logic                         full,
  input  logic                         req_pop,
  output slr_pkg::req_t                req_data,
  output logic                         req_empty
);

  slr_pkg::req_t req_in;
  logic          q_full;
  logic          q_push;

  // Classify: a client beyond the table is denied without touching state
  always_comb begin
    req_in.in_range     = (32'(client_index) < NUM_CLIENTS);
    req_in.client_index = client_index;
    req_in.timestamp_ms = timestamp_ms;
  end

  // No request is taken while the back end clears its tables
  assign full   = q_full || busy;
  assign q_push = push && !full;

  slr_fifo #(
    .WIDTH ($bits(slr_pkg::req_t)),
    .DEPTH (slr_pkg::QUEUE_DEPTH)
  ) u_req_q (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (req_in),
    .full      (q_full),
    .pop       (req_pop),
    .pop_data  (req_data),
    .empty     (req_empty)
  );

endmodule

// ===== hw/rtl/slr_back.sv =====
// Back end: per-client ring bookkeeping, expiry walk, decision, result queue.
module slr_back #(
  parameter int NUM_CLIENTS = slr_pkg::NUM_CLIENTS_DEF,
  parameter int LOG_DEPTH   = slr_pkg::LOG_DEPTH_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  slr_pkg::cfg_t cfg,
  input  slr_pkg::req_t req_data,
  input  logic          req_empty,
  output logic          req_pop,
  output logic          busy,
  output logic          out_allowed,
  output logic          empty,
  input  logic          pop
);

  localparam int CW    = (NUM_CLIENTS > 1) ? $clog2(NUM_CLIENTS) : 1;
  localparam int HW    = (LOG_DEPTH > 1) ? $clog2(LOG_DEPTH) : 1;
  localparam int CNTW  = $clog2(LOG_DEPTH + 1);
  localparam int SW    = CNTW + 1;
  localparam int MW    = HW + CNTW;
  localparam int TOTAL = NUM_CLIENTS * LOG_DEPTH;
  localparam int AW    = (TOTAL > 1) ? $clog2(TOTAL) : 1;
  localparam int STW   = slr_pkg::STAMP_W;

  slr_pkg::back_state_t state_r, state_nxt;
  logic [CW-1:0]   clr_idx_r, clr_idx_nxt;
  logic [CW-1:0]   client_r, client_nxt;
  logic [STW-1:0]  now_r, now_nxt;
  logic [AW-1:0]   base_r, base_nxt;
  logic [HW-1:0]   head_r, head_nxt;
  logic [CNTW-1:0] count_r, count_nxt;

  // Memory ports
  logic            meta_wr_en, meta_rd_en;
  logic [CW-1:0]   meta_wr_addr, meta_rd_addr;
  logic [MW-1:0]   meta_wr_data, meta_rd_data;
  logic            stamp_wr_en, stamp_rd_en;
  logic [AW-1:0]   stamp_wr_addr, stamp_rd_addr;
  logic [STW-1:0]  stamp_rd_data;

  // Result queue
  logic            res_push, res_data, res_full;

  // Helpers
  logic [CW-1:0]   req_client;
  logic [HW-1:0]   meta_head, head_inc, rd_head;
  logic [CNTW-1:0] meta_count, count_dec;
  logic [STW-1:0]  age;
  logic            expire, allow;
  logic [SW-1:0]   slot_sum, slot;

  assign req_client = CW'(req_data.client_index);
  assign meta_head  = meta_rd_data[MW-1:CNTW];
  assign meta_count = meta_rd_data[CNTW-1:0];
  assign head_inc   = (head_r == HW'(LOG_DEPTH - 1)) ? '0 : head_r + 1'b1;
  assign count_dec  = count_r - 1'b1;

  // Oldest stamp expires once its age reaches the window; future stamps never do
  assign age    = now_r - stamp_rd_data;
  assign expire = (now_r >= stamp_rd_data) && (age >= STW'(cfg.window_ms));

  // Admit while under both the configured limit and the ring depth
  assign allow = (count_r < CNTW'(LOG_DEPTH)) &&
                 (32'(count_r) < 32'(cfg.req_limit));

  // Append slot: (head + count) wrapped at the ring depth
  assign slot_sum = SW'(head_r) + SW'(count_r);
  assign slot     = (slot_sum >= SW'(LOG_DEPTH)) ? slot_sum - SW'(LOG_DEPTH) : slot_sum;

  assign busy          = (state_r == slr_pkg::ST_CLEAR);
  assign stamp_rd_addr = base_r + AW'(rd_head);
  assign stamp_wr_addr = base_r + AW'(slot);

  // Sequencer
  always_comb begin
    state_nxt    = state_r;
    clr_idx_nxt  = clr_idx_r;
    client_nxt   = client_r;
    now_nxt      = now_r;
    base_nxt     = base_r;
    head_nxt     = head_r;
    count_nxt    = count_r;
    req_pop      = 1'b0;
    meta_wr_en   = 1'b0;
    meta_wr_addr = client_r;
    meta_wr_data = {head_r, count_r};
    meta_rd_en   = 1'b0;
    meta_rd_addr = req_client;
    stamp_rd_en  = 1'b0;
    rd_head      = head_inc;
    stamp_wr_en  = 1'b0;
    res_push     = 1'b0;
    res_data     = 1'b0;
    case (state_r)
      slr_pkg::ST_CLEAR: begin
        // Zero one client's head and count per cycle after reset
        meta_wr_en   = 1'b1;
        meta_wr_addr = clr_idx_r;
        meta_wr_data = '0;
        clr_idx_nxt  = clr_idx_r + 1'b1;
        if (clr_idx_r == CW'(NUM_CLIENTS - 1)) begin
          state_nxt = slr_pkg::ST_IDLE;
        end
      end
      slr_pkg::ST_IDLE: begin
        if (!req_empty && !res_full) begin
          req_pop = 1'b1;
          if (!req_data.in_range) begin
            res_push = 1'b1;
            res_data = 1'b0;
          end else begin
            meta_rd_en = 1'b1;
            client_nxt = req_client;
            now_nxt    = req_data.timestamp_ms;
            base_nxt   = AW'(32'(req_client) * LOG_DEPTH);
            state_nxt  = slr_pkg::ST_META;
          end
        end
      end
      slr_pkg::ST_META: begin
        head_nxt  = meta_head;
        count_nxt = meta_count;
        if (meta_count != '0) begin
          stamp_rd_en = 1'b1;
          rd_head     = meta_head;
          state_nxt   = slr_pkg::ST_STAMP;
        end else begin
          state_nxt = slr_pkg::ST_DECIDE;
        end
      end
      slr_pkg::ST_STAMP: begin
        // Pop expired stamps from the oldest end, one read per cycle
        if (expire) begin
          head_nxt  = head_inc;
          count_nxt = count_dec;
          if (count_dec != '0) begin
            stamp_rd_en = 1'b1;
            rd_head     = head_inc;
          end else begin
            state_nxt = slr_pkg::ST_DECIDE;
          end
        end else begin
          state_nxt = slr_pkg::ST_DECIDE;
        end
      end
      slr_pkg::ST_DECIDE: begin
        stamp_wr_en  = allow;
        meta_wr_en   = 1'b1;
        meta_wr_data = {head_r, allow ? count_r + 1'b1 : count_r};
        res_push     = 1'b1;
        res_data     = allow;
        state_nxt    = slr_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = slr_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= slr_pkg::ST_CLEAR;
      clr_idx_r <= '0;
    end else begin
      state_r   <= state_nxt;
      clr_idx_r <= clr_idx_nxt;
    end
  end

  // Per-request working registers
  always_ff @(posedge clk) begin
    client_r <= client_nxt;
    now_r    <= now_nxt;
    base_r   <= base_nxt;
    head_r   <= head_nxt;
    count_r  <= count_nxt;
  end

  // Per-client head and count
  slr_ram #(
    .WIDTH (MW),
    .DEPTH (NUM_CLIENTS)
  ) u_meta_ram (
    .clk     (clk),
    .wr_en   (meta_wr_en),
    .wr_addr (meta_wr_addr),
    .wr_data (meta_wr_data),
    .rd_en   (meta_rd_en),
    .rd_addr (meta_rd_addr),
    .rd_data (meta_rd_data)
  );

  // Stamp rings, one block of LOG_DEPTH entries per client
  slr_ram #(
    .WIDTH (STW),
    .DEPTH (TOTAL)
  ) u_stamp_ram (
    .clk     (clk),
    .wr_en   (stamp_wr_en),
    .wr_addr (stamp_wr_addr),
    .wr_data (now_r),
    .rd_en   (stamp_rd_en),
    .rd_addr (stamp_rd_addr),
    .rd_data (stamp_rd_data)
  );

  slr_fifo #(
    .WIDTH (1),
    .DEPTH (slr_pkg::QUEUE_DEPTH)
  ) u_res_q (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_push),
    .push_data (res_data),
    .full      (res_full),
    .pop       (pop),
    .pop_data  (out_allowed),
    .empty     (empty)
  );

endmodule
